### sv/mprc_pkg.sv
// Shared constants, types and codes for the median-predictive residual coder.
// Used by every module of the block; no dependencies.
package mprc_pkg;

    // Image geometry and sample widths
    localparam int MAX_LINE_WIDTH = 512;
    localparam int LINE_ADDR_BITS = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_BITS     = 10;
    localparam int PIXEL_BITS     = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int SYMBOL_BITS    = 16;
    localparam int RECON_BITS     = 18;
    localparam int STEP_BITS      = 4;

    // Error and divider widths: |e| fits RECON_BITS, 2|e| + step one more bit
    localparam int ERR_BITS       = RECON_BITS + 1;
    localparam int MAG_BITS       = RECON_BITS;
    localparam int NUM_BITS       = MAG_BITS + 2;
    localparam int DEN_BITS       = STEP_BITS + 1;
    localparam int DIV_STEP_BITS  = 8;
    localparam int DIV_CYCLES     = (NUM_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DIV_WORK_BITS  = DIV_CYCLES * DIV_STEP_BITS;
    localparam int DIV_CNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int PROD_BITS      = NUM_BITS + STEP_BITS;

    // Configuration port
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = WIDTH_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUANT_STEP = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH = 1'b1;
    localparam logic [STEP_BITS-1:0]  QUANT_STEP_RESET = 4'd2;
    localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = 10'd512;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_ERR,
        ST_DIV,
        ST_FIN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic pred;
        logic load;
        logic div_step;
        logic fin;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### sv/mprc_pix_if.sv
// Input pixel channel: valid/ready handshake carrying pixel and frame start.
// Depends on mprc_pkg for the sample width.
interface mprc_pix_if;
    logic                              valid;
    logic                              ready;
    logic [mprc_pkg::SAMPLE_BITS-1:0]  pixel;
    logic                              frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

### sv/mprc_sym_if.sv
// Output symbol channel: valid/ready handshake carrying the zigzag symbol.
// Depends on mprc_pkg for the symbol width.
interface mprc_sym_if;
    logic                              valid;
    logic                              ready;
    logic [mprc_pkg::SYMBOL_BITS-1:0]  symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

### sv/mprc_div.sv
// Iterative restoring divider, DIV_STEP_BITS quotient bits per run cycle.
// Depends on mprc_pkg for widths and the cycle count.
module mprc_div (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_run,
    input  logic [mprc_pkg::NUM_BITS-1:0]    i_num,
    input  logic [mprc_pkg::DEN_BITS-1:0]    i_den,
    output logic [mprc_pkg::NUM_BITS-1:0]    o_quo
);

    logic [mprc_pkg::DIV_WORK_BITS-1:0] r_work, n_work;
    logic [mprc_pkg::DEN_BITS-1:0]      r_rem, n_rem;
    logic [mprc_pkg::DEN_BITS-1:0]      r_den;

    // Shift numerator bits into the remainder, quotient bits into the work word
    always_comb begin
        logic [mprc_pkg::DEN_BITS:0] part;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < mprc_pkg::DIV_STEP_BITS; k++) begin
            part = {n_rem, n_work[mprc_pkg::DIV_WORK_BITS-1]};
            if (part >= {1'b0, r_den}) begin
                part   = part - {1'b0, r_den};
                n_work = {n_work[mprc_pkg::DIV_WORK_BITS-2:0], 1'b1};
            end else begin
                n_work = {n_work[mprc_pkg::DIV_WORK_BITS-2:0], 1'b0};
            end
            n_rem = part[mprc_pkg::DEN_BITS-1:0];
        end
    end

    // Load operands, then advance one group of bits per run cycle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_work <= mprc_pkg::DIV_WORK_BITS'(i_num);
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (i_run) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_quo = r_work[mprc_pkg::NUM_BITS-1:0];

endmodule

### sv/mprc_ctrl.sv
// Controller for the coder: sequences predict, error, divide and finish steps.
// Depends on mprc_pkg for states, command and status types.
module mprc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mprc_pkg::t_status  i_status,
    output mprc_pkg::t_cmd     o_cmd
);

    mprc_pkg::t_state r_state, n_state;
    logic [mprc_pkg::DIV_CNT_BITS-1:0] r_div_cnt, n_div_cnt;
    logic div_last;

    assign div_last = (r_div_cnt == mprc_pkg::DIV_CNT_BITS'(mprc_pkg::DIV_CYCLES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mprc_pkg::ST_IDLE: if (i_in_valid) n_state = mprc_pkg::ST_PRED;
            mprc_pkg::ST_PRED: n_state = mprc_pkg::ST_ERR;
            mprc_pkg::ST_ERR:  n_state = mprc_pkg::ST_DIV;
            mprc_pkg::ST_DIV:  if (div_last) n_state = mprc_pkg::ST_FIN;
            mprc_pkg::ST_FIN:  if (i_status.out_free) n_state = mprc_pkg::ST_IDLE;
            default:           n_state = mprc_pkg::ST_IDLE;
        endcase
    end

    // Divider cycle count: clear on load, advance while dividing
    always_comb begin
        n_div_cnt = r_div_cnt;
        if (r_state == mprc_pkg::ST_ERR) begin
            n_div_cnt = '0;
        end else if (r_state == mprc_pkg::ST_DIV && !div_last) begin
            n_div_cnt = r_div_cnt + 1'b1;
        end
    end

    // Outputs
    always_comb begin
        o_in_ready      = (r_state == mprc_pkg::ST_IDLE);
        o_cmd.accept    = (r_state == mprc_pkg::ST_IDLE) && i_in_valid;
        o_cmd.pred      = (r_state == mprc_pkg::ST_PRED);
        o_cmd.load      = (r_state == mprc_pkg::ST_ERR);
        o_cmd.div_step  = (r_state == mprc_pkg::ST_DIV);
        o_cmd.fin       = (r_state == mprc_pkg::ST_FIN) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mprc_pkg::ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

### sv/mprc_datapath.sv
// Datapath: config registers, line store, MED predictor, quantiser, output register.
// Depends on mprc_pkg and instantiates mprc_div.
module mprc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mprc_pkg::t_cmd                      i_cmd,
    output mprc_pkg::t_status                   o_status,
    input  logic [mprc_pkg::SAMPLE_BITS-1:0]    i_pixel,
    input  logic                                i_frame_start,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mprc_pkg::SYMBOL_BITS-1:0]    o_symbol,
    input  logic                                i_cfg_we,
    input  logic [mprc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mprc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int RB = mprc_pkg::RECON_BITS;
    localparam int AB = mprc_pkg::LINE_ADDR_BITS;
    localparam int WB = mprc_pkg::WIDTH_BITS;

    // Configuration
    logic [mprc_pkg::STEP_BITS-1:0] r_quant_step;
    logic [WB-1:0]                  r_line_width;
    logic [mprc_pkg::STEP_BITS-1:0] step;
    logic [WB-1:0]                  width_eff;

    // Line store and neighbour state
    logic [RB-1:0] r_line [mprc_pkg::MAX_LINE_WIDTH];
    logic [RB-1:0] r_rdata;
    logic [RB-1:0] r_left, r_above_left;
    logic [AB-1:0] r_col;
    logic          r_first;

    // Per-pixel working registers
    logic [mprc_pkg::SAMPLE_BITS-1:0] r_pix;
    logic [AB-1:0]                    r_cur_col;
    logic                             r_cur_first;
    logic [RB-1:0]                    r_pred;
    logic                             r_neg;
    logic                             r_out_valid;
    logic [mprc_pkg::SYMBOL_BITS-1:0] r_symbol;

    logic [AB-1:0] rd_addr;
    logic signed [RB-1:0] a, b, c, lo, hi, pred;
    logic signed [RB+1:0] plane;
    logic signed [mprc_pkg::ERR_BITS-1:0] d;
    logic [mprc_pkg::ERR_BITS-1:0]  d_abs;
    logic [mprc_pkg::NUM_BITS-1:0]  num;
    logic [mprc_pkg::DEN_BITS-1:0]  den;
    logic [mprc_pkg::NUM_BITS-1:0]  quo;
    logic [mprc_pkg::PROD_BITS-1:0] prod;
    logic [RB-1:0]  recon;
    logic           q_neg;
    logic [mprc_pkg::SYMBOL_BITS-1:0] symbol;
    logic [WB-1:0]  col_inc;
    logic           row_end;

    // Step zero codes as lossless; out-of-range widths fall back to the full line
    assign step = (r_quant_step == '0) ? mprc_pkg::STEP_BITS'(1) : r_quant_step;
    assign width_eff = (r_line_width == '0 ||
                        r_line_width > WB'(mprc_pkg::MAX_LINE_WIDTH))
                       ? WB'(mprc_pkg::MAX_LINE_WIDTH) : r_line_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_step <= mprc_pkg::QUANT_STEP_RESET;
            r_line_width <= mprc_pkg::LINE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mprc_pkg::CFG_QUANT_STEP:
                    r_quant_step <= i_cfg_data[mprc_pkg::STEP_BITS-1:0];
                mprc_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame start restarts at column 0 of the first row
    assign rd_addr = i_frame_start ? '0 : r_col;

    // Line store: read on transfer, write back the reconstruction on finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_rdata <= r_line[rd_addr];
        if (i_cmd.fin)    r_line[r_cur_col] <= recon;
    end

    // Capture the accepted pixel and its position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix       <= i_pixel & mprc_pkg::SAMPLE_BITS'((1 << mprc_pkg::PIXEL_BITS) - 1);
            r_cur_col   <= rd_addr;
            r_cur_first <= i_frame_start | r_first;
        end
    end

    // Median edge detector; neighbours outside the image read as zero
    always_comb begin
        a  = (r_cur_col == '0) ? '0 : $signed(r_left);
        b  = r_cur_first ? '0 : $signed(r_rdata);
        c  = (r_cur_col == '0 || r_cur_first) ? '0 : $signed(r_above_left);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        plane = {{2{a[RB-1]}}, a} + {{2{b[RB-1]}}, b} - {{2{c[RB-1]}}, c};
        if (c > hi)      pred = lo;
        else if (c < lo) pred = hi;
        else             pred = plane[RB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pred) r_pred <= pred;
    end

    // Error and rounding numerator 2|e| + step over denominator 2*step
    always_comb begin
        d     = $signed({{(mprc_pkg::ERR_BITS - mprc_pkg::SAMPLE_BITS){1'b0}}, r_pix})
                - $signed({r_pred[RB-1], r_pred});
        d_abs = d[mprc_pkg::ERR_BITS-1] ? -d : d;
        num   = {1'b0, d_abs[mprc_pkg::MAG_BITS-1:0], 1'b0}
                + mprc_pkg::NUM_BITS'(step);
        den   = {step, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_neg <= d[mprc_pkg::ERR_BITS-1];
    end

    mprc_div u_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_run  (i_cmd.div_step),
        .i_num  (num),
        .i_den  (den),
        .o_quo  (quo)
    );

    // Reconstruction, zigzag symbol and next position
    always_comb begin
        prod    = mprc_pkg::PROD_BITS'(quo) * mprc_pkg::PROD_BITS'(step);
        recon   = r_neg ? (r_pred - prod[RB-1:0]) : (r_pred + prod[RB-1:0]);
        q_neg   = r_neg && (quo != '0);
        symbol  = {quo[mprc_pkg::SYMBOL_BITS-2:0], 1'b0}
                  - mprc_pkg::SYMBOL_BITS'(q_neg);
        col_inc = WB'(r_cur_col) + WB'(1);
        row_end = (col_inc >= width_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_above_left <= '0;
            r_col        <= '0;
            r_first      <= 1'b1;
        end else if (i_cmd.fin) begin
            r_left       <= recon;
            r_above_left <= r_rdata;
            r_col        <= row_end ? '0 : col_inc[AB-1:0];
            r_first      <= row_end ? 1'b0 : r_cur_first;
        end
    end

    // Output register: fill on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) r_symbol <= symbol;
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_symbol          = r_symbol;

endmodule

### sv/med_predictive_residual_coder_core.sv
// Near-lossless median-predictive residual coder, top level.
// Depends on mprc_pkg, mprc_pix_if, mprc_sym_if, mprc_ctrl and mprc_datapath.
//
// Usage:
//   i_pix carries 16-bit pixels in raster order; frame_start marks the first
//   pixel of an image. o_sym returns one zigzag residual symbol per pixel,
//   in order. Both channels transfer on a clock edge with valid and ready high.
//   i_cfg_we/i_cfg_idx/i_cfg_data write quant_step (index 0) and line_width
//   (index 1); write them only between pixels, with no symbol outstanding.
// Timing:
//   A pixel passes through the predict, error, divide and finish states before its
//   symbol is valid; a new pixel is taken only the cycle after the previous one
//   finishes. The pace is set by the 20-bit rounding divide (8 quotient bits a
//   cycle) behind a predict stage and an error stage, and by the left neighbour,
//   which is only known once the previous pixel is reconstructed.
// Reset and stall:
//   Synchronous active-low reset clears the position to the first row,
//   the neighbours to zero and the registers to step 2, width 512. The line
//   store is not cleared; the first row ignores what it reads from it.
//   A finished symbol waits in the output register while the next pixel is
//   taken and worked on; that pixel then holds in its final step until the
//   receiver takes the waiting symbol.
module med_predictive_residual_coder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mprc_pix_if.sink                            i_pix,
    mprc_sym_if.source                          o_sym,
    input  logic                                i_cfg_we,
    input  logic [mprc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mprc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    mprc_pkg::t_cmd    cmd;
    mprc_pkg::t_status status;

    mprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mprc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_out_ready   (o_sym.ready),
        .o_out_valid   (o_sym.valid),
        .o_symbol      (o_sym.symbol),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

endmodule

### sim/mprc_symbol_checker.sv
`timescale 1ns / 1ps
// Symbol checker for the median-predictive residual coder: watches both channels
// and the register port, predicts each symbol and compares it. Needs mprc_pkg
// and the mprc_pix_if / mprc_sym_if interfaces.
module mprc_symbol_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mprc_pix_if                                 i_pix,
    mprc_sym_if                                 i_sym,
    input  logic                                i_cfg_we,
    input  logic [mprc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [mprc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                  o_mismatches,
    output int                                  o_outstanding
);
    import mprc_pkg::*;

    localparam int MAX_REPORTS = 40;

    // Predictor state: reconstructed row above, neighbours and raster position
    logic signed [RECON_BITS-1:0] line_recon [MAX_LINE_WIDTH];
    logic signed [RECON_BITS-1:0] left_rec;
    logic signed [RECON_BITS-1:0] upleft_rec;
    int                           col_pos;
    logic                         in_first_row;
    logic [STEP_BITS-1:0]         step_cfg;
    logic [WIDTH_BITS-1:0]        width_cfg;

    logic [SYMBOL_BITS-1:0]       expected_symbols [$];
    int                           mismatch_count;

    assign o_mismatches = mismatch_count;

    // Print one line per mismatch, up to a cap, and count every one
    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] symbol check: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Code one pixel: median prediction, rounding quantizer, reconstruction
    task automatic predict_symbol(input logic [SAMPLE_BITS-1:0] pix, input logic fs,
                                  output logic [SYMBOL_BITS-1:0] sym);
        int eff_step;
        int eff_width;
        int col;
        int pix_i;
        int a;
        int b;
        int c;
        int lo;
        int hi;
        int pred;
        int diff;
        int mag;
        int q;
        int rec;
        int zz;
        logic signed [RECON_BITS-1:0] old_up;
        eff_step  = (step_cfg == 0) ? 1 : int'(step_cfg);
        eff_width = (width_cfg == 0 || width_cfg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH
                                                                   : int'(width_cfg);
        if (fs) begin
            col_pos      = 0;
            in_first_row = 1'b1;
        end
        col    = col_pos % MAX_LINE_WIDTH;
        pix_i  = pix;
        old_up = line_recon[col];
        a = (col == 0) ? 0 : int'(left_rec);
        b = in_first_row ? 0 : int'(old_up);
        c = (col == 0 || in_first_row) ? 0 : int'(upleft_rec);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c > hi)
            pred = lo;
        else if (c < lo)
            pred = hi;
        else
            pred = a + b - c;

        // Round half away from zero on the magnitude, then restore the sign
        diff = pix_i - pred;
        mag  = (diff < 0) ? -diff : diff;
        q    = (2 * mag + eff_step) / (2 * eff_step);
        if (diff < 0)
            q = -q;

        // Store the reconstruction wrapped to the recon width
        rec             = pred + q * eff_step;
        upleft_rec      = old_up;
        line_recon[col] = rec[RECON_BITS-1:0];
        left_rec        = rec[RECON_BITS-1:0];

        zz  = (q < 0) ? (-2 * q - 1) : (2 * q);
        sym = zz[SYMBOL_BITS-1:0];

        // Advance the raster position; a row ends at or past the width
        col = col + 1;
        if (col >= eff_width) begin
            col          = 0;
            in_first_row = 1'b0;
        end
        col_pos = col;
    endtask

    // Sample every transfer on the rising edge
    always @(posedge i_clk) begin
        logic [SYMBOL_BITS-1:0] want;
        logic [SYMBOL_BITS-1:0] next_sym;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LINE_WIDTH; i++)
                line_recon[i] = '0;
            left_rec       = '0;
            upleft_rec     = '0;
            col_pos        = 0;
            in_first_row   = 1'b1;
            step_cfg       = QUANT_STEP_RESET;
            width_cfg      = LINE_WIDTH_RESET;
            mismatch_count = 0;
            expected_symbols.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_QUANT_STEP)
                    step_cfg = i_cfg_data[STEP_BITS-1:0];
                else if (i_cfg_idx == CFG_LINE_WIDTH)
                    width_cfg = i_cfg_data[WIDTH_BITS-1:0];
            end

            // Compare an output transfer with the oldest expectation
            if (i_sym.valid && i_sym.ready) begin
                if (expected_symbols.size() == 0) begin
                    report_mismatch($sformatf("unexpected symbol %h", i_sym.symbol));
                end else begin
                    want = expected_symbols.pop_front();
                    if (i_sym.symbol !== want)
                        report_mismatch($sformatf("symbol got %h want %h",
                                                  i_sym.symbol, want));
                end
            end

            // Predict the symbol for an input transfer
            if (i_pix.valid && i_pix.ready) begin
                predict_symbol(i_pix.pixel, i_pix.frame_start, next_sym);
                expected_symbols.push_back(next_sym);
            end
        end
        o_outstanding <= expected_symbols.size();
    end

endmodule

### sim/med_predictive_residual_coder_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for med_predictive_residual_coder_core: drives pixels in bursts,
// stalls the symbol sink, walks the registers and gives the verdict.
// Needs mprc_pkg, both channel interfaces, the core and mprc_symbol_checker.
module med_predictive_residual_coder_core_tb;
    import mprc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int SETTLE_CYC   = 12;
    localparam int LONG_HOLD    = 250;
    localparam int RANDOM_ITEMS = 290;
    localparam int WIDE_ITEMS   = 530;

    typedef enum int {PIX_UNIFORM, PIX_SMOOTH, PIX_EXTREME, PIX_FLAT} t_pix_mode;

    // Directed pixels as {frame_start, pixel}
    localparam logic [16:0] DIRECTED [23] = '{
        {1'b1, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF},
        {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h8000},
        {1'b0, 16'h0001}, {1'b0, 16'hFFFE}, {1'b1, 16'hFFFF}, {1'b0, 16'h0000},
        {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0007}, {1'b0, 16'h0008},
        {1'b0, 16'hFFFF}, {1'b0, 16'h0000},
        {1'b1, 16'd100},  {1'b0, 16'd200},  {1'b0, 16'd50},   {1'b0, 16'h0000},
        {1'b0, 16'hFFFF}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = CFG_QUANT_STEP;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int   mismatches;
    int   outstanding;
    int   burst_left    = 0;
    int   items_sent    = 0;
    int   prev_eff      = MAX_LINE_WIDTH;
    logic offering      = 1'b0;
    logic sink_hold_req = 1'b0;
    logic [SAMPLE_BITS-1:0] last_pix = '0;

    mprc_pix_if pix_ch ();
    mprc_sym_if sym_ch ();

    med_predictive_residual_coder_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_sym      (sym_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mprc_symbol_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix_ch),
        .i_sym         (sym_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        pix_ch.valid       = 1'b0;
        pix_ch.pixel       = '0;
        pix_ch.frame_start = 1'b0;
        sym_ch.ready       = 1'b0;
    end

    // Effective width: zero or too large means the full line
    function automatic int eff_width(input logic [WIDTH_BITS-1:0] w);
        return (w == 0 || w > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(w);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] next_pixel(input t_pix_mode mode,
                                                          input logic [SAMPLE_BITS-1:0] prev);
        logic [SAMPLE_BITS-1:0] v;
        case (mode)
            PIX_UNIFORM: v = SAMPLE_BITS'($urandom);
            PIX_SMOOTH:  v = prev + SAMPLE_BITS'($urandom_range(0, 32)) - 16'd16;
            PIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = SAMPLE_BITS'($urandom_range(0, 15));
                    default: v = 16'hFFFF - SAMPLE_BITS'($urandom_range(0, 15));
                endcase
            end
            default:     v = prev ^ SAMPLE_BITS'($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    // Write both registers back to back; the block must be idle
    task automatic set_config(input logic [STEP_BITS-1:0] step_val,
                              input logic [WIDTH_BITS-1:0] width_val);
        logic [CFG_DATA_BITS-1:0] step_word;
        step_word = CFG_DATA_BITS'($urandom);
        step_word[STEP_BITS-1:0] = step_val;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_QUANT_STEP;
        cfg_data <= step_word;
        @(posedge i_clk);
        cfg_idx  <= CFG_LINE_WIDTH;
        cfg_data <= CFG_DATA_BITS'(width_val);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        prev_eff = eff_width(width_val);
    endtask

    task automatic stop_offering();
        if (offering) begin
            pix_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one pixel and hold it until transfer; gap between bursts
    task automatic send_pixel(input logic [SAMPLE_BITS-1:0] pix, input logic fs);
        if (burst_left == 0) begin
            stop_offering();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(8, 20)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= pix;
        pix_ch.frame_start <= fs;
        offering = 1'b1;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
        burst_left--;
        items_sent++;
    endtask

    // Hold the input until every expected symbol is back, then settle
    task automatic wait_drained();
        stop_offering();
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_directed(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_pixel(DIRECTED[i][15:0], DIRECTED[i][16]);
        wait_drained();
    endtask

    // One phase at fixed settings; a wider row needs a fresh frame first
    task automatic run_phase(input logic [STEP_BITS-1:0] step_val,
                             input logic [WIDTH_BITS-1:0] width_val,
                             input int count, input t_pix_mode mode, input logic hold);
        logic need_fs;
        logic fs;
        int   pause_at;
        logic [SAMPLE_BITS-1:0] pix;
        need_fs = (eff_width(width_val) > prev_eff) || ($urandom_range(0, 3) == 0);
        set_config(step_val, width_val);
        if (hold)
            sink_hold_req = 1'b1;
        pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                wait_drained();
            fs  = (i == 0 && need_fs) || ($urandom_range(0, 63) == 0);
            pix = next_pixel(mode, last_pix);
            send_pixel(pix, fs);
            last_pix = pix;
        end
        wait_drained();
    endtask

    // Symbol sink: ready and stall stretches, plus a long hold on request
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                sym_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 7) == 0) begin
                sym_ch.ready <= 1'b1;
                repeat ($urandom_range(40, 80)) @(posedge i_clk);
            end else begin
                sym_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                sym_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int                    phase_no;
        int                    count;
        logic [STEP_BITS-1:0]  step_val;
        logic [WIDTH_BITS-1:0] width_val;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lossless extremes, then a narrower row mid-row, then step zero
        set_config(4'd1, 10'd4);
        send_directed(0, 11);
        set_config(4'd15, 10'd1);
        send_directed(12, 17);
        set_config(4'd0, 10'd2);
        send_directed(18, 22);

        // Random phases, mostly narrow rows
        phase_no   = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       step_val = 4'd0;
                1:       step_val = 4'd1;
                2:       step_val = 4'd8;
                3:       step_val = 4'd15;
                default: step_val = STEP_BITS'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 9))
                0:       width_val = 10'd1;
                1:       width_val = 10'd0;
                2:       width_val = 10'd512;
                3:       width_val = WIDTH_BITS'($urandom_range(513, 1023));
                4, 5:    width_val = WIDTH_BITS'($urandom_range(17, 64));
                default: width_val = WIDTH_BITS'($urandom_range(2, 16));
            endcase
            if (phase_no == 0)
                width_val = 10'd0;
            else if (phase_no == 1)
                width_val = 10'd1023;
            count = $urandom_range(12, 60);
            run_phase(step_val, width_val, count, t_pix_mode'($urandom_range(0, 3)),
                      phase_no == 3 || phase_no == 9);
            phase_no++;
        end

        // One full-width image deep enough to read the row above
        run_phase(STEP_BITS'($urandom_range(1, 15)), 10'd512, WIDE_ITEMS, PIX_SMOOTH, 1'b0);

        if (mismatches == 0)
            $display("med_predictive_residual_coder_core verification clean");
        else
            $display("med_predictive_residual_coder_core verification failed");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("med_predictive_residual_coder_core verification failed");
        $finish;
    end

endmodule
